// ----- rtl/nbg_pkg.sv -----
// nbg_pkg: types, constants and saturation helper for the n-body update block.
// No dependencies; used by every other file of the block but nbg_if.
package nbg_pkg;

   localparam int FRAC = 16;
   localparam int QW   = 63 - FRAC;
   localparam int TW   = 38;
   localparam int UW   = FRAC + 1;
   localparam int PW   = TW + UW;
   localparam int MW   = PW - FRAC;

   localparam logic [TW-1:0] TERM_CAP = {TW{1'b1}};
   localparam logic [63:0]   U_ONE    = 64'd1 << FRAC;

   localparam logic [31:0] GRAVITY_RESET = 32'd1000 << FRAC;
   localparam logic [10:0] COUNT_RESET   = 11'd1000;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   localparam logic REG_GRAVITY = 1'b0;
   localparam logic REG_COUNT   = 1'b1;

   localparam logic [1:0] LAST_AXIS = 2'd2;

   localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
   localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OWN_RD,
      ST_OWN_CAP,
      ST_FETCH,
      ST_DIFF,
      ST_SQ,
      ST_SQ_CHK,
      ST_SQRT_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MUL,
      ST_ACC,
      ST_VEL,
      ST_POS,
      ST_DONE
   } nbg_state_type;

   typedef enum logic [1:0] {
      DK_Q,
      DK_T,
      DK_U
   } nbg_div_kind_type;

   typedef struct packed {
      logic busy;
      logic done;
   } nbg_unit_stat_type;

   // {clip, value}
   function automatic logic [32:0] sat32(input logic signed [64:0] v);
      logic [32:0] r;
      if (v > SAT_HI) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < SAT_LO) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

// ----- rtl/nbg_if.sv -----
// nbg_if: valid/ready channel interfaces for request and response transactions.
// No dependencies.
interface nbg_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [9:0]         body_index;
   logic signed [31:0] load_pos_x;
   logic signed [31:0] load_pos_y;
   logic signed [31:0] load_pos_z;
   logic signed [31:0] load_vel_x;
   logic signed [31:0] load_vel_y;
   logic signed [31:0] load_vel_z;

   modport source (output valid, op, body_index, load_pos_x, load_pos_y, load_pos_z,
                   load_vel_x, load_vel_y, load_vel_z, input ready);
   modport sink (input valid, op, body_index, load_pos_x, load_pos_y, load_pos_z,
                 load_vel_x, load_vel_y, load_vel_z, output ready);
endinterface

interface nbg_rsp_if;
   logic               valid;
   logic               ready;
   logic [9:0]         result_index;
   logic signed [31:0] new_pos_x;
   logic signed [31:0] new_pos_y;
   logic signed [31:0] new_pos_z;
   logic               saturated;

   modport source (output valid, result_index, new_pos_x, new_pos_y, new_pos_z, saturated,
                   input ready);
   modport sink (input valid, result_index, new_pos_x, new_pos_y, new_pos_z, saturated,
                 output ready);
endinterface

// ----- rtl/nbg_isqrt.sv -----
// nbg_isqrt: bit-serial integer square root of a 64-bit value, one root bit per cycle.
// Depends on nbg_pkg.
module nbg_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [63:0]                value,
   output logic [31:0]                root,
   output nbg_pkg::nbg_unit_stat_type stat
);
   localparam int STEPS = 32;
   localparam int CW    = $clog2(STEPS + 1);

   logic [63:0]   val_ff;
   logic [33:0]   rem_ff, rem_in;
   logic [31:0]   root_ff, root_in;
   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [35:0]   rem_sh, trial;
   logic          ge;

   always_comb begin
      rem_sh  = {rem_ff, val_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem_sh >= trial;
      rem_in  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      root_in = {root_ff[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            val_ff  <= value;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= CW'(STEPS);
         end else if (cnt_ff != '0) begin
            val_ff  <= {val_ff[61:0], 2'b00};
            rem_ff  <= rem_in;
            root_ff <= root_in;
            cnt_ff  <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign root      = root_ff;
   assign stat.busy = cnt_ff != '0;
   assign stat.done = done_ff;
endmodule

// ----- rtl/nbg_div.sv -----
// nbg_div: restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit per cycle.
// Depends on nbg_pkg.
module nbg_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [63:0]                dividend,
   input  logic [32:0]                divisor,
   output logic [63:0]                quotient,
   output nbg_pkg::nbg_unit_stat_type stat
);
   localparam int STEPS = 64;
   localparam int CW    = $clog2(STEPS + 1);

   logic [63:0]   quo_ff;
   logic [32:0]   rem_ff, rem_in;
   logic [32:0]   div_ff;
   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [33:0]   rem_sh;
   logic          ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[63]};
      ge     = rem_sh >= {1'b0, div_ff};
      rem_in = ge ? 33'(rem_sh - {1'b0, div_ff}) : rem_sh[32:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff <= dividend;
            rem_ff <= '0;
            div_ff <= divisor;
            cnt_ff <= CW'(STEPS);
         end else if (cnt_ff != '0) begin
            quo_ff <= {quo_ff[62:0], ge};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = cnt_ff != '0;
   assign stat.done = done_ff;
endmodule

// ----- rtl/nbody_gravity_body_update.sv -----
// Direct-sum gravity body update. Body positions and velocities (Q16.16) sit in two
// synchronous memories; a load transaction writes one body. An update transaction
// reads the body, then walks partners 0..min(body_count,MAX_BODIES)-1 one at a time
// through a shared 64-step divider (five divisions per partner, four when g/d
// saturates the term) and a 32-step square root; a coincident partner is skipped.
// An update may also wait for the response register to free. The new state is
// written back in place and the new position returned; the response register holds
// a finished result while the next transaction is taken. No clearing pass after reset.
// Depends on nbg_pkg, nbg_if, nbg_isqrt, nbg_div.
module nbody_gravity_body_update #(
   parameter int MAX_BODIES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   nbg_req_if.sink      req_ch,
   nbg_rsp_if.source    rsp_ch,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int AW = $clog2(MAX_BODIES);
   localparam int CW = $clog2(MAX_BODIES + 1);

   nbg_pkg::nbg_state_type    state_ff, state_in;
   nbg_pkg::nbg_div_kind_type dk_ff, dk_in;

   logic [31:0] gravity_ff;
   logic [10:0] count_ff;

   logic [95:0] pos_mem [MAX_BODIES];
   logic [95:0] vel_mem [MAX_BODIES];
   logic [95:0] pos_q_ff, vel_q_ff;
   logic [95:0] pos_wdata, vel_wdata;
   logic [AW-1:0] pos_raddr, mem_waddr, idx_addr, req_addr;
   logic          mem_we;

   logic [9:0]              idx_ff, idx_in;
   logic [CW-1:0]           j_ff, j_in, n_w;
   logic [1:0]              k_ff, k_in;
   logic [65:0]             s2_ff, s2_in;
   logic [32:0]             d_ff, d_in;
   logic [nbg_pkg::QW-1:0]  q_ff, q_in;
   logic [nbg_pkg::TW-1:0]  t_ff, t_in;
   logic [nbg_pkg::UW-1:0]  u_ff, u_in;
   logic [nbg_pkg::PW-1:0]  prod_ff, prod_in;
   logic                    clip_ff, clip_in;

   logic signed [31:0] own_pos_ff [3], own_pos_in [3];
   logic signed [31:0] own_vel_ff [3], own_vel_in [3];
   logic signed [32:0] dx_ff [3], dx_in [3];
   logic signed [63:0] acc_ff [3], acc_in [3];
   logic signed [31:0] nv_ff [3], nv_in [3];
   logic signed [31:0] np_ff [3], np_in [3];
   logic signed [31:0] pq [3], vq [3];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [9:0]         rsp_index_ff, rsp_index_in;
   logic signed [31:0] rsp_pos_ff [3], rsp_pos_in [3];
   logic               rsp_sat_ff, rsp_sat_in;

   logic        req_ready, req_idx_ok, rsp_free;
   logic [32:0] dx_neg;
   logic [31:0] mag_w;
   logic [63:0] sq_w;
   logic [nbg_pkg::MW-1:0] m_w;
   logic signed [63:0]     term_w;
   logic [32:0]            sat_w;

   logic                       sqrt_start;
   logic [63:0]                sqrt_value;
   logic [31:0]                sqrt_root;
   nbg_pkg::nbg_unit_stat_type sqrt_stat;
   logic                       div_start;
   logic [63:0]                div_dividend, div_quot;
   nbg_pkg::nbg_unit_stat_type div_stat;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == nbg_pkg::REG_COUNT) ? 32'(count_ff) : gravity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= nbg_pkg::GRAVITY_RESET;
         count_ff   <= nbg_pkg::COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == nbg_pkg::REG_GRAVITY) begin
            gravity_ff <= csr_pwdata;
         end else begin
            count_ff <= csr_pwdata[10:0];
         end
      end
   end

   assign n_w = (32'(count_ff) < 32'(MAX_BODIES)) ? CW'(count_ff) : CW'(MAX_BODIES);

   // state memories
   assign idx_addr   = AW'(idx_ff);
   assign req_addr   = AW'(req_ch.body_index);
   assign req_idx_ok = 32'(req_ch.body_index) < 32'(MAX_BODIES);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem[mem_waddr] <= pos_wdata;
         vel_mem[mem_waddr] <= vel_wdata;
      end
      pos_q_ff <= pos_mem[pos_raddr];
      vel_q_ff <= vel_mem[idx_addr];
   end

   // arithmetic units
   nbg_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_value),
      .root  (sqrt_root),
      .stat  (sqrt_stat)
   );

   nbg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (d_ff),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         pq[c] = pos_q_ff[32*c +: 32];
         vq[c] = vel_q_ff[32*c +: 32];
      end
      dx_neg     = -dx_ff[k_ff];
      mag_w      = dx_ff[k_ff][32] ? dx_neg[31:0] : dx_ff[k_ff][31:0];
      sq_w       = mag_w * mag_w;
      m_w        = prod_ff[nbg_pkg::PW-1:nbg_pkg::FRAC];
      term_w     = dx_ff[k_ff][32] ? -$signed(64'(m_w)) : $signed(64'(m_w));
      sqrt_value = (s2_ff[65:64] != 2'b00) ? s2_ff[65:2] : s2_ff[63:0];
      case (dk_ff)
         nbg_pkg::DK_Q: div_dividend = 64'(gravity_ff) << nbg_pkg::FRAC;
         nbg_pkg::DK_T: div_dividend = 64'(q_ff) << nbg_pkg::FRAC;
         nbg_pkg::DK_U: div_dividend = 64'(mag_w) << nbg_pkg::FRAC;
         default:       div_dividend = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      dk_in        = dk_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      s2_in        = s2_ff;
      d_in         = d_ff;
      q_in         = q_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      prod_in      = prod_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_sat_in   = rsp_sat_ff;
      sat_w        = '0;
      for (int c = 0; c < 3; c++) begin
         own_pos_in[c] = own_pos_ff[c];
         own_vel_in[c] = own_vel_ff[c];
         dx_in[c]      = dx_ff[c];
         acc_in[c]     = acc_ff[c];
         nv_in[c]      = nv_ff[c];
         np_in[c]      = np_ff[c];
         rsp_pos_in[c] = rsp_pos_ff[c];
      end
      mem_we     = 1'b0;
      mem_waddr  = idx_addr;
      pos_wdata  = {np_ff[2], np_ff[1], np_ff[0]};
      vel_wdata  = {nv_ff[2], nv_ff[1], nv_ff[0]};
      pos_raddr  = idx_addr;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      req_ready  = 1'b0;
      rsp_free   = !rsp_valid_ff || rsp_ch.ready;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         nbg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid && req_idx_ok) begin
               if (req_ch.op == nbg_pkg::OP_LOAD) begin
                  mem_we    = 1'b1;
                  mem_waddr = req_addr;
                  pos_wdata = {req_ch.load_pos_z, req_ch.load_pos_y, req_ch.load_pos_x};
                  vel_wdata = {req_ch.load_vel_z, req_ch.load_vel_y, req_ch.load_vel_x};
               end else begin
                  idx_in   = req_ch.body_index;
                  state_in = nbg_pkg::ST_OWN_RD;
               end
            end
         end
         nbg_pkg::ST_OWN_RD: begin
            state_in = nbg_pkg::ST_OWN_CAP;
         end
         nbg_pkg::ST_OWN_CAP: begin
            for (int c = 0; c < 3; c++) begin
               own_pos_in[c] = pq[c];
               own_vel_in[c] = vq[c];
               acc_in[c]     = '0;
            end
            j_in     = '0;
            clip_in  = 1'b0;
            state_in = nbg_pkg::ST_FETCH;
         end
         nbg_pkg::ST_FETCH: begin
            if (j_ff >= n_w) begin
               state_in = nbg_pkg::ST_VEL;
            end else begin
               pos_raddr = j_ff[AW-1:0];
               state_in  = nbg_pkg::ST_DIFF;
            end
         end
         nbg_pkg::ST_DIFF: begin
            for (int c = 0; c < 3; c++) begin
               dx_in[c] = 33'(pq[c]) - 33'(own_pos_ff[c]);
            end
            k_in     = '0;
            s2_in    = '0;
            state_in = nbg_pkg::ST_SQ;
         end
         nbg_pkg::ST_SQ: begin
            s2_in = s2_ff + 66'(sq_w);
            if (k_ff == nbg_pkg::LAST_AXIS) begin
               state_in = nbg_pkg::ST_SQ_CHK;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         nbg_pkg::ST_SQ_CHK: begin
            if (s2_ff == '0) begin
               j_in     = j_ff + CW'(1);
               state_in = nbg_pkg::ST_FETCH;
            end else begin
               sqrt_start = 1'b1;
               state_in   = nbg_pkg::ST_SQRT_WAIT;
            end
         end
         nbg_pkg::ST_SQRT_WAIT: begin
            if (sqrt_stat.done) begin
               d_in     = (s2_ff[65:64] != 2'b00) ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
               dk_in    = nbg_pkg::DK_Q;
               state_in = nbg_pkg::ST_DIV_GO;
            end
         end
         nbg_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = nbg_pkg::ST_DIV_WAIT;
         end
         nbg_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               case (dk_ff)
                  nbg_pkg::DK_Q: begin
                     if ((div_quot >> nbg_pkg::QW) != '0) begin
                        t_in  = nbg_pkg::TERM_CAP;
                        k_in  = '0;
                        dk_in = nbg_pkg::DK_U;
                     end else begin
                        q_in  = div_quot[nbg_pkg::QW-1:0];
                        dk_in = nbg_pkg::DK_T;
                     end
                     state_in = nbg_pkg::ST_DIV_GO;
                  end
                  nbg_pkg::DK_T: begin
                     t_in = (div_quot > 64'(nbg_pkg::TERM_CAP)) ? nbg_pkg::TERM_CAP
                                                              : div_quot[nbg_pkg::TW-1:0];
                     k_in     = '0;
                     dk_in    = nbg_pkg::DK_U;
                     state_in = nbg_pkg::ST_DIV_GO;
                  end
                  nbg_pkg::DK_U: begin
                     u_in = (div_quot > nbg_pkg::U_ONE) ? nbg_pkg::U_ONE[nbg_pkg::UW-1:0]
                                                       : div_quot[nbg_pkg::UW-1:0];
                     state_in = nbg_pkg::ST_MUL;
                  end
                  default: begin
                     state_in = nbg_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         nbg_pkg::ST_MUL: begin
            prod_in  = t_ff * u_ff;
            state_in = nbg_pkg::ST_ACC;
         end
         nbg_pkg::ST_ACC: begin
            acc_in[k_ff] = acc_ff[k_ff] + term_w;
            if (k_ff == nbg_pkg::LAST_AXIS) begin
               j_in     = j_ff + CW'(1);
               state_in = nbg_pkg::ST_FETCH;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = nbg_pkg::ST_DIV_GO;
            end
         end
         nbg_pkg::ST_VEL: begin
            for (int c = 0; c < 3; c++) begin
               sat_w    = nbg_pkg::sat32(65'(own_vel_ff[c]) + 65'(acc_ff[c]));
               nv_in[c] = sat_w[31:0];
               if (sat_w[32]) begin
                  clip_in = 1'b1;
               end
            end
            state_in = nbg_pkg::ST_POS;
         end
         nbg_pkg::ST_POS: begin
            for (int c = 0; c < 3; c++) begin
               sat_w    = nbg_pkg::sat32(65'(own_pos_ff[c]) + 65'(nv_ff[c]));
               np_in[c] = sat_w[31:0];
               if (sat_w[32]) begin
                  clip_in = 1'b1;
               end
            end
            state_in = nbg_pkg::ST_DONE;
         end
         nbg_pkg::ST_DONE: begin
            if (rsp_free) begin
               mem_we       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_ff;
               rsp_sat_in   = clip_ff;
               for (int c = 0; c < 3; c++) begin
                  rsp_pos_in[c] = np_ff[c];
               end
               state_in = nbg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nbg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nbg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dk_ff        <= dk_in;
      idx_ff       <= idx_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      s2_ff        <= s2_in;
      d_ff         <= d_in;
      q_ff         <= q_in;
      t_ff         <= t_in;
      u_ff         <= u_in;
      prod_ff      <= prod_in;
      clip_ff      <= clip_in;
      rsp_index_ff <= rsp_index_in;
      rsp_sat_ff   <= rsp_sat_in;
      for (int c = 0; c < 3; c++) begin
         own_pos_ff[c] <= own_pos_in[c];
         own_vel_ff[c] <= own_vel_in[c];
         dx_ff[c]      <= dx_in[c];
         acc_ff[c]     <= acc_in[c];
         nv_ff[c]      <= nv_in[c];
         np_ff[c]      <= np_in[c];
         rsp_pos_ff[c] <= rsp_pos_in[c];
      end
   end

   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_index = rsp_index_ff;
   assign rsp_ch.new_pos_x    = rsp_pos_ff[0];
   assign rsp_ch.new_pos_y    = rsp_pos_ff[1];
   assign rsp_ch.new_pos_z    = rsp_pos_ff[2];
   assign rsp_ch.saturated    = rsp_sat_ff;

`ifndef SYNTHESIS
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_sqrt_idle: assert property (@(posedge clock) disable iff (reset)
      sqrt_start |-> !sqrt_stat.busy)
      else $error("square root started while busy");

   a_partner_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nbg_pkg::ST_DIFF) |-> (j_ff < n_w))
      else $error("partner index beyond active bodies");

   a_rsp_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nbg_pkg::ST_DONE && !rsp_valid_ff) |=> rsp_ch.valid)
      else $error("finished update not presented");
`endif

endmodule

// ----- verif/nbg_update_checker.sv -----
`timescale 1ns / 100ps
// nbg_update_checker: watches request, response and register transactions of the n-body
// update block, predicts each new body position and compares it. Depends on nbg_pkg, nbg_if.
module nbg_update_checker (
   input  logic        clock,
   input  logic        reset,
   nbg_req_if          req_ch,
   nbg_rsp_if          rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          outstanding
);

   localparam int NB = 1024;
   localparam logic [2:0] ADDR_GRAVITY = 3'd0;
   localparam logic [2:0] ADDR_COUNT   = 3'd4;

   typedef struct {
      logic [9:0]         idx;
      logic signed [31:0] px, py, pz;
      logic               sat;
   } new_pos_type;

   logic signed [31:0] pos_x[NB], pos_y[NB], pos_z[NB];
   logic signed [31:0] vel_x[NB], vel_y[NB], vel_z[NB];
   logic [31:0] gravity;
   logic [10:0] count;
   new_pos_type pending_pos[$];

   initial outstanding = 0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] magn(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [63:0] axis_term(input logic signed [63:0] dv,
                                                    input logic [63:0] d,
                                                    input logic [63:0] t);
      logic [63:0] u, m;
      u = (magn(dv) << nbg_pkg::FRAC) / d;
      if (u > nbg_pkg::U_ONE) u = nbg_pkg::U_ONE;
      m = (t * u) >> nbg_pkg::FRAC;
      return dv < 0 ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] clip32(input logic signed [63:0] v,
                                                 inout logic clipped);
      if (v > 64'sd2147483647) begin
         clipped = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         clipped = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic new_pos_type step_body(input logic [9:0] idx);
      new_pos_type res;
      logic signed [63:0] px, py, pz, dx, dy, dz, ax, ay, az;
      logic [65:0] s;
      logic [63:0] d, q, t;
      logic signed [31:0] vx, vy, vz;
      int n;
      logic clipped;
      px = pos_x[idx];
      py = pos_y[idx];
      pz = pos_z[idx];
      ax = 0;
      ay = 0;
      az = 0;
      clipped = 1'b0;
      n = count < NB ? count : NB;
      for (int j = 0; j < n; j++) begin
         dx = 64'(pos_x[j]) - px;
         dy = 64'(pos_y[j]) - py;
         dz = 64'(pos_z[j]) - pz;
         if (dx == 0 && dy == 0 && dz == 0) continue;
         s = 66'(magn(dx) * magn(dx)) + 66'(magn(dy) * magn(dy)) + 66'(magn(dz) * magn(dz));
         if (s[65:64] != 0) d = int_sqrt(s[65:2]) << 1;
         else d = int_sqrt(s[63:0]);
         if (d == 0) continue;
         q = (64'(gravity) << nbg_pkg::FRAC) / d;
         if ((q >> nbg_pkg::QW) != 0) begin
            t = 64'(nbg_pkg::TERM_CAP);
         end else begin
            t = (q << nbg_pkg::FRAC) / d;
            if (t > 64'(nbg_pkg::TERM_CAP)) t = 64'(nbg_pkg::TERM_CAP);
         end
         ax += axis_term(dx, d, t);
         ay += axis_term(dy, d, t);
         az += axis_term(dz, d, t);
      end
      vx = clip32(64'(vel_x[idx]) + ax, clipped);
      vy = clip32(64'(vel_y[idx]) + ay, clipped);
      vz = clip32(64'(vel_z[idx]) + az, clipped);
      res.px = clip32(px + vx, clipped);
      res.py = clip32(py + vy, clipped);
      res.pz = clip32(pz + vz, clipped);
      vel_x[idx] = vx;
      vel_y[idx] = vy;
      vel_z[idx] = vz;
      pos_x[idx] = res.px;
      pos_y[idx] = res.py;
      pos_z[idx] = res.pz;
      res.idx = idx;
      res.sat = clipped;
      return res;
   endfunction

   always @(posedge clock) begin
      new_pos_type e;
      if (reset) begin
         gravity = nbg_pkg::GRAVITY_RESET;
         count = nbg_pkg::COUNT_RESET;
         pending_pos.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_GRAVITY) gravity = csr_pwdata;
            else if (csr_paddr == ADDR_COUNT) count = csr_pwdata[10:0];
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_pos.size() == 0) begin
               $error("unexpected transaction: index %0d", rsp_ch.result_index);
               fail_count++;
            end else begin
               e = pending_pos.pop_front();
               if (rsp_ch.result_index !== e.idx) begin
                  $error("result_index exp %0d got %0d", e.idx, rsp_ch.result_index);
                  fail_count++;
               end
               if (rsp_ch.new_pos_x !== e.px) begin
                  $error("new_pos_x exp %0d got %0d", e.px, rsp_ch.new_pos_x);
                  fail_count++;
               end
               if (rsp_ch.new_pos_y !== e.py) begin
                  $error("new_pos_y exp %0d got %0d", e.py, rsp_ch.new_pos_y);
                  fail_count++;
               end
               if (rsp_ch.new_pos_z !== e.pz) begin
                  $error("new_pos_z exp %0d got %0d", e.pz, rsp_ch.new_pos_z);
                  fail_count++;
               end
               if (rsp_ch.saturated !== e.sat) begin
                  $error("saturated exp %0d got %0d", e.sat, rsp_ch.saturated);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.op == nbg_pkg::OP_LOAD) begin
               pos_x[req_ch.body_index] = req_ch.load_pos_x;
               pos_y[req_ch.body_index] = req_ch.load_pos_y;
               pos_z[req_ch.body_index] = req_ch.load_pos_z;
               vel_x[req_ch.body_index] = req_ch.load_vel_x;
               vel_y[req_ch.body_index] = req_ch.load_vel_y;
               vel_z[req_ch.body_index] = req_ch.load_vel_z;
            end else begin
               pending_pos.insert(pending_pos.size(), step_body(req_ch.body_index));
            end
         end
      end
      outstanding = pending_pos.size();
   end

endmodule

// ----- verif/tb_nbody_gravity_body_update.sv -----
`timescale 1ns / 100ps
// tb_nbody_gravity_body_update: drives load/update and register transactions into the
// n-body update block with random idling; verdict from nbg_update_checker.
module tb_nbody_gravity_body_update;

   localparam int LIMIT = 4000000;
   localparam logic [2:0] ADDR_GRAVITY = 3'd0;
   localparam logic [2:0] ADDR_COUNT   = 3'd4;
   localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] PMIN = 32'sh8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int fail_count, outstanding;
   int cycles = 0;
   bit quiet = 0;
   bit hold_req = 0;

   nbg_req_if req_ch();
   nbg_rsp_if rsp_ch();

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   nbody_gravity_body_update dut (
      .clock, .reset, .req_ch, .rsp_ch,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   nbg_update_checker u_chk (
      .clock, .reset, .req_ch, .rsp_ch,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .outstanding
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.op = nbg_pkg::OP_LOAD;
      req_ch.body_index = '0;
      req_ch.load_pos_x = '0;
      req_ch.load_pos_y = '0;
      req_ch.load_pos_z = '0;
      req_ch.load_vel_x = '0;
      req_ch.load_vel_y = '0;
      req_ch.load_vel_z = '0;
      rsp_ch.ready = 1'b0;
   end

   // result sink
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 19);
         if (hold_req) begin
            hold_req = 0;
            gap = 600;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send(input logic op, input logic [9:0] idx,
                       input logic signed [31:0] px, py, pz, vx, vy, vz);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.body_index <= idx;
      req_ch.load_pos_x <= px;
      req_ch.load_pos_y <= py;
      req_ch.load_pos_z <= pz;
      req_ch.load_vel_x <= vx;
      req_ch.load_vel_y <= vy;
      req_ch.load_vel_z <= vz;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic update(input logic [9:0] idx);
      send(nbg_pkg::OP_UPDATE, idx, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom);
   endtask

   // wait for all results, then let a trailing load finish
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 2))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
         default: return $signed($urandom_range(0, 1024)) - 32'sd512;
      endcase
   endfunction

   function automatic logic [31:0] rand_gravity();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h10_0000);
         2: return nbg_pkg::GRAVITY_RESET;
         default: return $urandom_range(0, 32'hFFFF);
      endcase
   endfunction

   initial begin
      logic signed [31:0] p;
      int n_items;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of state and gravity
      csr_write(ADDR_COUNT, 32'd4);
      csr_write(ADDR_GRAVITY, 32'hFFFF_FFFF);
      send(nbg_pkg::OP_LOAD, 10'd0, 0, 0, 0, 0, 0, 0);
      send(nbg_pkg::OP_LOAD, 10'd1, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX);
      send(nbg_pkg::OP_LOAD, 10'd2, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN);
      send(nbg_pkg::OP_LOAD, 10'd3, 32'sh1_0000, 0, 0, 0, 0, 0);
      send(nbg_pkg::OP_LOAD, 10'd1023, 0, 0, 0, 32'sd5, -32'sd5, 0);
      update(10'd0);
      update(10'd1);
      update(10'd2);
      update(10'd3);
      update(10'd1023);
      drain();
      csr_write(ADDR_GRAVITY, 32'd0);
      csr_write(ADDR_COUNT, 32'd0);
      update(10'd1);
      update(10'd3);
      drain();
      csr_write(ADDR_GRAVITY, 32'd1);
      csr_write(ADDR_COUNT, 32'd1);
      update(10'd3);
      update(10'd0);
      drain();

      // a cluster of coincident bodies, then one partner moved off it
      quiet = 1;
      p = rand_coord();
      for (int i = 0; i < 32; i++) send(nbg_pkg::OP_LOAD, i[9:0], p, p, p, 0, 0, 0);
      quiet = 0;
      drain();
      csr_write(ADDR_GRAVITY, nbg_pkg::GRAVITY_RESET);
      csr_write(ADDR_COUNT, 32'd32);
      update(10'd5);
      drain();
      send(nbg_pkg::OP_LOAD, 10'd20, p + 32'sd100, p, p, 0, 0, 0);
      update(10'd6);
      drain();

      // random phases over the loaded bodies
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(ADDR_GRAVITY, rand_gravity());
         csr_write(ADDR_COUNT, ph == 5 ? $urandom_range(5, 8) : $urandom_range(1, 4));
         quiet = (ph == 3);
         if (ph == 2) hold_req = 1;
         n_items = 65;
         for (int k = 0; k < n_items; k++) begin
            if (ph == 4 && k == 35) drain();
            if ($urandom_range(0, 9) < 3)
               send(nbg_pkg::OP_LOAD, 10'($urandom), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord());
            else if ($urandom_range(0, 3) == 0)
               update(10'($urandom_range(0, 7)));
            else
               update(10'($urandom_range(0, 31)));
         end
         drain();
      end

      if (fail_count == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
